@@ rtl/core/assert_macros.svh @@
// assertion macros for the rtl top level of the glyph generator
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/fgg_pkg.sv @@
// shared types, constants and the 5x7 font rom of the glyph generator
// no dependencies
`default_nettype none

package fgg_pkg;

  // panel size
  localparam int PANEL_WIDTH  = 320;
  localparam int PANEL_HEIGHT = 240;

  // glyph geometry
  localparam int GLYPH_W = 5;
  localparam int GLYPH_H = 7;
  localparam int ADVANCE = 6;

  localparam int CUR_W    = 10;
  localparam int WIN_W    = 9;
  localparam int ROW_W    = 8;
  localparam int CODE_W   = 8;
  localparam int COLOR_W  = 16;
  localparam int RIDX_W   = 3;
  localparam logic [RIDX_W-1:0] LAST_RIDX = RIDX_W'(GLYPH_H - 1);
  localparam logic [CUR_W-1:0]  CUR_MAX   = {CUR_W{1'b1}};

  // register map, index = paddr[3:2]
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_FG_COLOR    = 2'd0;
  localparam logic [1:0] REG_BG_COLOR    = 2'd1;
  localparam logic [1:0] REG_DRAW_ENABLE = 2'd2;

  // stream widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 104;

  // one glyph: five columns, bit r of a column is glyph row r
  typedef logic [GLYPH_W-1:0][GLYPH_H-1:0] glyph_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic               draw_enable;
  } cfg_t;

  // one character to draw, queued from front to back
  typedef struct packed {
    glyph_t           glyph;
    logic [WIN_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cmd_t;

  // queue write request and full flag, driven by the front end
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  function automatic logic [COLOR_W-1:0] swap_bytes(input logic [COLOR_W-1:0] c);
    swap_bytes = {c[7:0], c[15:8]};
  endfunction

  // font rom, columns listed right to left (column 4 first); codes without a glyph are blank
  function automatic glyph_t font_lookup(input logic [CODE_W-1:0] code);
    logic [4:0][7:0] c;
    glyph_t g;
    c = '0;
    unique case (code)
      8'h2E: c = {8'h40, 8'h00, 8'h00, 8'h00, 8'h00};
      8'h30: c = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      8'h31: c = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      8'h32: c = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
      8'h33: c = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
      8'h34: c = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      8'h35: c = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
      8'h36: c = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
      8'h37: c = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      8'h38: c = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39: c = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
      8'h61: c = {8'h78, 8'h54, 8'h54, 8'h54, 8'h20};
      8'h63: c = {8'h20, 8'h44, 8'h44, 8'h44, 8'h38};
      8'h64: c = {8'h38, 8'h40, 8'h40, 8'h20, 8'h7F};
      8'h65: c = {8'h18, 8'h54, 8'h54, 8'h54, 8'h38};
      8'h66: c = {8'h02, 8'h09, 8'h7E, 8'h08, 8'h00};
      8'h67: c = {8'h3C, 8'h54, 8'h54, 8'h54, 8'h08};
      8'h69: c = {8'h00, 8'h40, 8'h7F, 8'h41, 8'h00};
      8'h6C: c = {8'h00, 8'h40, 8'h7F, 8'h41, 8'h00};
      8'h6D: c = {8'h78, 8'h04, 8'h18, 8'h04, 8'h7C};
      8'h6E: c = {8'h78, 8'h04, 8'h04, 8'h08, 8'h7C};
      8'h6F: c = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
      8'h70: c = {8'h08, 8'h14, 8'h14, 8'h14, 8'h7C};
      8'h72: c = {8'h08, 8'h04, 8'h04, 8'h08, 8'h7C};
      8'h73: c = {8'h24, 8'h54, 8'h54, 8'h54, 8'h48};
      8'h74: c = {8'h20, 8'h40, 8'h44, 8'h3F, 8'h04};
      8'h75: c = {8'h7C, 8'h20, 8'h40, 8'h40, 8'h3C};
      8'h76: c = {8'h3C, 8'h40, 8'h40, 8'h40, 8'h3C};
      default: c = '0;
    endcase
    for (int i = 0; i < GLYPH_W; i++) begin
      g[i] = c[i][GLYPH_H-1:0];
    end
    font_lookup = g;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/font5x7_text_glyph_generator_top.sv @@
// 5x7 text glyph generator, top level
// depends on fgg_pkg, fgg_regs, fgg_front, fgg_queue, fgg_back, assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

// Takes one character per input word and turns each drawn character into seven
// output words, one per glyph row, each carrying five RGB565 pixels (byte-swapped)
// plus the column and panel row; tlast marks the seventh row. A word with
// tuser=1 starts a new text at its start column and row. A character that would
// cross the right or bottom panel edge stops the text until the next start;
// with draw_enable=0 nothing is drawn and the cursor holds. The row sequencer in
// the back end emits one glyph row per cycle while the output is not stalled;
// rows of consecutive characters follow without gaps if the next is queued.
// A suppressed character is accepted but never queued. A two-entry command
// queue sits between the character decoder and the row sequencer.
module font5x7_text_glyph_generator_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata: char_code[7:0], start_col[16:8], start_row[24:17], zero fill
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [fgg_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: first_char
  input  wire logic                            in_tuser,
  // out_tdata: win_col[8:0], pix_row[16:9], pixel_0..pixel_4 [96:17], zero fill
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [fgg_pkg::OUT_DATA_W-1:0]       out_tdata,
  // out_tlast: last_row
  output logic                                 out_tlast,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [fgg_pkg::ADDR_W-1:0]      cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic      [31:0]                     cfg_prdata,
  output logic                                 cfg_pready
);

  fgg_pkg::cfg_t  cfg;
  fgg_pkg::q_wr_t q_wr;
  fgg_pkg::cmd_t  q_wdata;
  fgg_pkg::cmd_t  q_rdata;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;

  fgg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  fgg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .draw_enable (cfg.draw_enable),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_wdata     (q_wdata)
  );

  fgg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_wr.push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  fgg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // queue never written while full, never read while empty
  `ASSERT_IMPL(a_q_no_overflow, q_wr.push, !q_wr.full)
  `ASSERT_IMPL(a_q_no_underflow, q_pop, q_valid)
  // rows of one glyph leave back to back
  `ASSERT_NEXT(a_rows_contiguous, out_tvalid && out_tready && !out_tlast, out_tvalid)

endmodule

`default_nettype wire

@@ rtl/core/fgg_regs.sv @@
// apb register file: fg_color, bg_color, draw_enable
// depends on fgg_pkg
`default_nettype none

module fgg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [fgg_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]               cfg_pwdata,
  output logic      [31:0]               cfg_prdata,
  output logic                           cfg_pready,
  output fgg_pkg::cfg_t                  cfg
);

  logic [15:0] fg_r;
  logic [15:0] bg_r;
  logic        en_r;
  logic        wr_en;
  logic [1:0]  idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 16'hFFFF;
      bg_r <= 16'h0000;
      en_r <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        fgg_pkg::REG_FG_COLOR:    fg_r <= cfg_pwdata[15:0];
        fgg_pkg::REG_BG_COLOR:    bg_r <= cfg_pwdata[15:0];
        fgg_pkg::REG_DRAW_ENABLE: en_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      fgg_pkg::REG_FG_COLOR:    cfg_prdata = {16'h0, fg_r};
      fgg_pkg::REG_BG_COLOR:    cfg_prdata = {16'h0, bg_r};
      fgg_pkg::REG_DRAW_ENABLE: cfg_prdata = {31'h0, en_r};
      default:                  cfg_prdata = 32'h0;
    endcase
  end

  assign cfg = '{fg_color: fg_r, bg_color: bg_r, draw_enable: en_r};

endmodule

`default_nettype wire

@@ rtl/core/fgg_front.sv @@
// front end: accepts characters, tracks cursor and stop, looks up the glyph
// depends on fgg_pkg
`default_nettype none

module fgg_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [fgg_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                            in_tuser,
  input  wire logic                            draw_enable,
  input  wire logic                            q_full,
  output fgg_pkg::q_wr_t                       q_wr,
  output fgg_pkg::cmd_t                        q_wdata
);

  logic [fgg_pkg::CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [fgg_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic                       stopped_r, stopped_nxt;

  logic [fgg_pkg::CODE_W-1:0] code;
  logic [fgg_pkg::WIN_W-1:0]  start_col;
  logic [fgg_pkg::ROW_W-1:0]  start_row;
  logic [fgg_pkg::CUR_W-1:0]  cur;
  logic [fgg_pkg::ROW_W-1:0]  row;
  logic                       stop;
  logic                       fits;
  logic                       draw;
  logic                       accept;
  logic [fgg_pkg::CUR_W:0]    col_end;
  logic [fgg_pkg::ROW_W:0]    row_end;
  logic [fgg_pkg::CUR_W:0]    adv;

  // unpack the word
  assign code      = in_tdata[7:0];
  assign start_col = in_tdata[16:8];
  assign start_row = in_tdata[24:17];

  assign in_tready = !q_full;
  assign accept    = in_tvalid & in_tready;

  // effective text position after a possible first-char load
  assign cur  = in_tuser ? {1'b0, start_col} : cursor_r;
  assign row  = in_tuser ? start_row : row_r;
  assign stop = in_tuser ? 1'b0 : stopped_r;

  // panel edge check
  assign col_end = {1'b0, cur} + (fgg_pkg::CUR_W+1)'(fgg_pkg::GLYPH_W);
  assign row_end = {1'b0, row} + (fgg_pkg::ROW_W+1)'(fgg_pkg::GLYPH_H);
  assign fits    = (col_end <= (fgg_pkg::CUR_W+1)'(fgg_pkg::PANEL_WIDTH)) &&
                   (row_end <= (fgg_pkg::ROW_W+1)'(fgg_pkg::PANEL_HEIGHT));
  assign draw    = draw_enable & !stop & fits;

  // saturating cursor advance
  assign adv = {1'b0, cur} + (fgg_pkg::CUR_W+1)'(fgg_pkg::ADVANCE);

  always_comb begin
    cursor_nxt  = cursor_r;
    row_nxt     = row_r;
    stopped_nxt = stopped_r;
    if (accept) begin
      cursor_nxt  = cur;
      row_nxt     = row;
      stopped_nxt = stop;
      if (draw_enable && !stop) begin
        if (fits) begin
          cursor_nxt = adv[fgg_pkg::CUR_W] ? fgg_pkg::CUR_MAX : adv[fgg_pkg::CUR_W-1:0];
        end else begin
          stopped_nxt = 1'b1;
        end
      end
    end
  end

  // text state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r  <= '0;
      row_r     <= '0;
      stopped_r <= 1'b0;
    end else begin
      cursor_r  <= cursor_nxt;
      row_r     <= row_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // command toward the back end
  assign q_wr.push    = accept & draw;
  assign q_wr.full    = q_full;
  assign q_wdata.glyph = fgg_pkg::font_lookup(code);
  assign q_wdata.col   = cur[fgg_pkg::WIN_W-1:0];
  assign q_wdata.row   = row;

endmodule

`default_nettype wire

@@ rtl/core/fgg_queue.sv @@
// two-entry command queue between front and back end
// depends on fgg_pkg
`default_nettype none

module fgg_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire fgg_pkg::cmd_t  wdata,
  output logic                full,
  input  wire logic           pop,
  output logic                rvalid,
  output fgg_pkg::cmd_t       rdata
);

  fgg_pkg::cmd_t mem [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r, count_nxt;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  assign full   = (count_r == 2'd2);
  assign rvalid = (count_r != 2'd0);
  assign rdata  = mem[rd_ptr_r];

endmodule

`default_nettype wire

@@ rtl/core/fgg_back.sv @@
// back end: walks the seven glyph rows and fills the output register
// depends on fgg_pkg
`default_nettype none

module fgg_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire fgg_pkg::cfg_t                  cfg,
  input  wire logic                           q_valid,
  input  wire fgg_pkg::cmd_t                  q_rdata,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [fgg_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast
);

  fgg_pkg::cmd_t                cmd_r;
  logic                         active_r;
  logic [fgg_pkg::RIDX_W-1:0]   ridx_r;
  logic                         out_valid_r;
  logic [fgg_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                         out_last_r;

  logic                         out_adv;
  logic                         emit;
  logic                         last;
  logic [fgg_pkg::COLOR_W-1:0]  fg_s;
  logic [fgg_pkg::COLOR_W-1:0]  bg_s;
  logic [fgg_pkg::GLYPH_W-1:0][fgg_pkg::COLOR_W-1:0] pix;
  logic [fgg_pkg::ROW_W-1:0]    pix_row;

  assign out_adv = !out_valid_r || out_tready;
  assign emit    = active_r && out_adv;
  assign last    = (ridx_r == fgg_pkg::LAST_RIDX);
  assign q_pop   = q_valid && (!active_r || (emit && last));

  // pixel colors for the current glyph row
  assign fg_s = fgg_pkg::swap_bytes(cfg.fg_color);
  assign bg_s = fgg_pkg::swap_bytes(cfg.bg_color);
  always_comb begin
    for (int c = 0; c < fgg_pkg::GLYPH_W; c++) begin
      pix[c] = cmd_r.glyph[c][ridx_r] ? fg_s : bg_s;
    end
  end
  assign pix_row = cmd_r.row + fgg_pkg::ROW_W'(ridx_r);

  // row sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ridx_r   <= '0;
    end else if (q_pop) begin
      active_r <= 1'b1;
      ridx_r   <= '0;
    end else if (emit) begin
      if (last) begin
        active_r <= 1'b0;
      end
      ridx_r <= ridx_r + fgg_pkg::RIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {7'h0, pix[4], pix[3], pix[2], pix[1], pix[0], pix_row, cmd_r.col};
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the 5x7 text glyph generator top level
// drives character words and apb register writes, predicts every glyph row word
// depends on fgg_pkg and font5x7_text_glyph_generator_top

module testbench;

  localparam int PANEL_W        = 320;
  localparam int PANEL_H        = 240;
  localparam int GLYPH_COLS     = 5;
  localparam int GLYPH_ROWS     = 7;
  localparam int CURSOR_STEP    = 6;
  localparam int CURSOR_MAX     = 1023;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_MAX     = 10;

  // one character word as seen on the input stream
  typedef struct packed {
    logic [7:0] code;
    logic       first;
    logic [8:0] col;
    logic [7:0] row;
  } char_word_t;

  // one glyph row word as seen on the output stream
  typedef struct packed {
    logic [8:0]       win_col;
    logic [7:0]       pix_row;
    logic [4:0][15:0] pixel;
    logic             last_row;
  } glyph_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [fgg_pkg::IN_DATA_W-1:0]    in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [fgg_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                             out_tlast;
  logic                             cfg_psel = 1'b0;
  logic                             cfg_penable = 1'b0;
  logic                             cfg_pwrite = 1'b0;
  logic [fgg_pkg::ADDR_W-1:0]       cfg_paddr = '0;
  logic [31:0]                      cfg_pwdata = '0;
  logic [31:0]                      cfg_prdata;
  logic                             cfg_pready;

  // words waiting to be sent and glyph rows waiting to come out
  char_word_t char_q[$];
  glyph_row_t glyph_rows_q[$];
  char_word_t cur_word;

  // shadow of the block's registers and text state
  logic [15:0] fg_shadow = 16'hFFFF;
  logic [15:0] bg_shadow = 16'h0000;
  logic        draw_en_shadow = 1'b1;
  int unsigned cursor_col = 0;
  logic [7:0]  text_row = '0;
  logic        text_stopped = 1'b0;

  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  logic        calm_in = 1'b0;
  logic        calm_out = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned fail_cnt = 0;
  int unsigned chars_sent = 0;
  int unsigned rows_checked = 0;
  int unsigned reg_writes = 0;

  string font_chars = " .0123456789acdefgilmnoprstuv";

  font5x7_text_glyph_generator_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // font columns, leftmost first; bit r is glyph row r, top row is bit 0
  function automatic logic [0:4][7:0] glyph_columns(input logic [7:0] code);
    case (code)
      8'h2E: glyph_columns = {8'h00, 8'h00, 8'h00, 8'h00, 8'h40};
      8'h30: glyph_columns = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      8'h31: glyph_columns = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      8'h32: glyph_columns = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      8'h33: glyph_columns = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      8'h34: glyph_columns = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      8'h35: glyph_columns = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      8'h36: glyph_columns = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      8'h37: glyph_columns = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      8'h38: glyph_columns = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39: glyph_columns = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      8'h61: glyph_columns = {8'h20, 8'h54, 8'h54, 8'h54, 8'h78};
      8'h63: glyph_columns = {8'h38, 8'h44, 8'h44, 8'h44, 8'h20};
      8'h64: glyph_columns = {8'h7F, 8'h20, 8'h40, 8'h40, 8'h38};
      8'h65: glyph_columns = {8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
      8'h66: glyph_columns = {8'h00, 8'h08, 8'h7E, 8'h09, 8'h02};
      8'h67: glyph_columns = {8'h08, 8'h54, 8'h54, 8'h54, 8'h3C};
      8'h69: glyph_columns = {8'h00, 8'h41, 8'h7F, 8'h40, 8'h00};
      8'h6C: glyph_columns = {8'h00, 8'h41, 8'h7F, 8'h40, 8'h00};
      8'h6D: glyph_columns = {8'h7C, 8'h04, 8'h18, 8'h04, 8'h78};
      8'h6E: glyph_columns = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h78};
      8'h6F: glyph_columns = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
      8'h70: glyph_columns = {8'h7C, 8'h14, 8'h14, 8'h14, 8'h08};
      8'h72: glyph_columns = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h08};
      8'h73: glyph_columns = {8'h48, 8'h54, 8'h54, 8'h54, 8'h24};
      8'h74: glyph_columns = {8'h04, 8'h3F, 8'h44, 8'h40, 8'h20};
      8'h75: glyph_columns = {8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C};
      8'h76: glyph_columns = {8'h3C, 8'h40, 8'h40, 8'h40, 8'h3C};
      default: glyph_columns = '0;
    endcase
  endfunction

  // glyph rows that one accepted character word should produce
  task automatic render_char(input char_word_t w);
    logic [0:4][7:0] cols;
    logic [15:0] fg_sw, bg_sw;
    glyph_row_t gr;
    if (w.first) begin
      cursor_col   = w.col;
      text_row     = w.row;
      text_stopped = 1'b0;
    end
    if (!draw_en_shadow || text_stopped) return;
    // glyph crosses the right or bottom edge: text stops here
    if (cursor_col + GLYPH_COLS > PANEL_W || int'(text_row) + GLYPH_ROWS > PANEL_H) begin
      text_stopped = 1'b1;
      return;
    end
    cols  = glyph_columns(w.code);
    fg_sw = {fg_shadow[7:0], fg_shadow[15:8]};
    bg_sw = {bg_shadow[7:0], bg_shadow[15:8]};
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      gr.win_col  = cursor_col[8:0];
      gr.pix_row  = text_row + 8'(r);
      for (int c = 0; c < GLYPH_COLS; c++) begin
        gr.pixel[c] = cols[c][r] ? fg_sw : bg_sw;
      end
      gr.last_row = (r == GLYPH_ROWS - 1);
      glyph_rows_q.push_back(gr);
    end
    cursor_col = cursor_col + CURSOR_STEP;
    if (cursor_col > CURSOR_MAX) cursor_col = CURSOR_MAX;
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input driver: presents queued words, holds them until accepted
  always @(posedge clk) begin : drive_chars
    if (in_tvalid && in_tready) begin
      render_char(cur_word);
      chars_sent++;
      if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
      in_gap = calm_in ? 0 : pick_gap();
    end
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
      // hold the current word
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (char_q.size() > 0) begin
      cur_word  = char_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= {7'b0, cur_word.row, cur_word.col, cur_word.code};
      in_tuser  <= cur_word.first;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // output monitor: checks each glyph row word and stalls at random
  always @(posedge clk) begin : check_rows
    glyph_row_t got, want;
    if (out_tvalid && out_tready) begin
      got.win_col  = out_tdata[8:0];
      got.pix_row  = out_tdata[16:9];
      for (int c = 0; c < GLYPH_COLS; c++) begin
        got.pixel[c] = out_tdata[17 + 16*c +: 16];
      end
      got.last_row = out_tlast;
      if (glyph_rows_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
          $display("unexpected glyph row word: col %0d row %0d", got.win_col, got.pix_row);
      end else begin
        want = glyph_rows_q.pop_front();
        rows_checked++;
        if (got != want) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX) begin
            $display("glyph row mismatch at word %0d:", rows_checked);
            if (got.win_col != want.win_col)
              $display("  win_col  expected %0d got %0d", want.win_col, got.win_col);
            if (got.pix_row != want.pix_row)
              $display("  pix_row  expected %0d got %0d", want.pix_row, got.pix_row);
            for (int c = 0; c < GLYPH_COLS; c++) begin
              if (got.pixel[c] != want.pixel[c])
                $display("  pixel_%0d  expected %h got %h", c, want.pixel[c], got.pixel[c]);
            end
            if (got.last_row != want.last_row)
              $display("  last_row expected %b got %b", want.last_row, got.last_row);
          end
        end
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      if (!calm_out && $urandom_range(0, 3) == 0) out_stall = pick_gap();
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // apb write: setup cycle, then access until pready
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      fgg_pkg::REG_FG_COLOR:    fg_shadow = data[15:0];
      fgg_pkg::REG_BG_COLOR:    bg_shadow = data[15:0];
      fgg_pkg::REG_DRAW_ENABLE: draw_en_shadow = data[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic queue_char(input logic [7:0] code, input logic first,
                            input int unsigned col, input int unsigned row);
    char_word_t w;
    w.code  = code;
    w.first = first;
    w.col   = col[8:0];
    w.row   = row[7:0];
    char_q.push_back(w);
  endtask

  // block idle: all words sent, all rows out, suppressed words flushed;
  // checked again after the settle time since the driver may load a word
  // in the same step as the first check
  task automatic wait_drained();
    do begin
      while (char_q.size() != 0 || in_tvalid || glyph_rows_q.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (char_q.size() != 0 || in_tvalid || glyph_rows_q.size() != 0);
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return font_chars[$urandom_range(0, font_chars.len() - 1)];
  endfunction

  // random texts: a start word then a run of characters, plus some noise words
  task automatic queue_random(input int unsigned count);
    int unsigned n, len, col, row;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        col = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 250) : $urandom_range(251, 319);
        row = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 233) : $urandom_range(234, 239);
        len = $urandom_range(1, 10);
        queue_char(pick_code(), 1'b1, col, row);
        for (int i = 0; i < len; i++)
          queue_char(pick_code(), 1'b0, $urandom_range(0, 319), $urandom_range(0, 239));
        n += len + 1;
      end else begin
        queue_char(8'($urandom_range(0, 255)), 1'(($urandom_range(0, 1))),
                   $urandom_range(0, 319), $urandom_range(0, 239));
        n++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset colors, field extremes, blank codes, both panel edges
    queue_char("0", 1'b1, 0, 0);
    queue_char("1", 1'b0, 0, 0);
    queue_char(8'hFF, 1'b0, 319, 239);
    queue_char(8'h00, 1'b0, 0, 0);
    queue_char(".", 1'b0, 0, 0);
    queue_char(" ", 1'b0, 0, 0);
    queue_char("v", 1'b1, 315, 233);
    queue_char("a", 1'b0, 0, 0);
    queue_char("8", 1'b0, 0, 0);
    queue_char("2", 1'b1, 100, 234);
    queue_char("3", 1'b0, 0, 0);
    queue_char("5", 1'b1, 319, 239);
    queue_char("m", 1'b1, 256, 128);
    queue_char("g", 1'b0, 63, 127);
    queue_char("p", 1'b1, 192, 64);
    wait_drained();

    // drawing disabled: start word still loads position, cursor holds
    write_reg(fgg_pkg::REG_DRAW_ENABLE, 32'h0);
    queue_char("a", 1'b1, 50, 50);
    queue_char("t", 1'b0, 0, 0);
    queue_char("9", 1'b1, 310, 200);
    wait_drained();
    write_reg(fgg_pkg::REG_DRAW_ENABLE, 32'h1);
    queue_char("c", 1'b0, 0, 0);
    queue_char("d", 1'b0, 0, 0);
    wait_drained();

    // random phases over several color settings
    write_reg(fgg_pkg::REG_FG_COLOR, 32'($urandom_range(0, 65535)));
    write_reg(fgg_pkg::REG_BG_COLOR, 32'($urandom_range(0, 65535)));
    queue_random(22);
    wait_drained();

    write_reg(fgg_pkg::REG_FG_COLOR, 32'h0000);
    write_reg(fgg_pkg::REG_BG_COLOR, 32'hFFFF);
    queue_random(22);
    wait_drained();

    write_reg(fgg_pkg::REG_DRAW_ENABLE, 32'h0);
    queue_random(4);
    wait_drained();
    write_reg(fgg_pkg::REG_DRAW_ENABLE, 32'h1);
    write_reg(fgg_pkg::REG_FG_COLOR, 32'h1234);
    write_reg(fgg_pkg::REG_BG_COLOR, 32'hA5C3);
    queue_random(22);
    wait_drained();

    if (glyph_rows_q.size() != 0) begin
      fail_cnt += glyph_rows_q.size();
      $display("%0d glyph row words never arrived", glyph_rows_q.size());
    end
    $display("sent %0d character words, compared %0d glyph row words, %0d register writes",
             chars_sent, rows_checked, reg_writes);
    $display("failures: %0d", fail_cnt);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
